FILE: hw/rtl/rpwu_pkg.sv
// shared types, constants and helpers for the readout packet word unpacker
package rpwu_pkg;

    localparam int FRONTEND_BITS = 2;
    localparam int SUB_BITS      = 2;
    localparam int MAX_PAIRS     = 2501;
    localparam int CHAN_BITS     = 7;
    localparam int KEY_BITS      = FRONTEND_BITS + SUB_BITS + CHAN_BITS;
    localparam int PAIR_BITS     = 13;

    localparam logic [11:0] PAD_MARK  = 12'hADD;
    localparam logic [7:0]  END_FIRST = 8'hEE;
    localparam logic [7:0]  END_SECOND = 8'hBB;

    localparam logic [15:0] COUNT_MAX = 16'hFFFF;
    localparam logic [31:0] TOTAL_MAX = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        PH_SKIP,
        PH_HEADER,
        PH_HITS
    } phase_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_READ,
        B_CLEAR
    } bstate_t;

    typedef logic [KEY_BITS-1:0] key_t;

    // one queue entry: an optional hit and an optional end-of-buffer clear
    typedef struct packed {
        logic        hit;
        logic        clr;
        logic [7:0]  frontend_id;
        logic [7:0]  sub_id;
        logic [7:0]  trigger_number;
        logic [47:0] trigger_time;
        logic [11:0] amplitude;
        logic [13:0] fine_time;
        logic [6:0]  channel;
        logic [23:0] coarse_epoch;
    } cmd_t;

    typedef struct packed {
        logic [7:0]  frontend_id;
        logic [7:0]  sub_id;
        logic [7:0]  trigger_number;
        logic [47:0] trigger_time;
        logic [11:0] amplitude;
        logic [13:0] fine_time;
        logic [6:0]  channel;
        logic [23:0] coarse_epoch;
        logic [15:0] channel_hit_index;
        logic [31:0] hit_number;
    } res_t;

    function automatic key_t make_key(input cmd_t c);
        make_key = {c.frontend_id[FRONTEND_BITS-1:0], c.sub_id[SUB_BITS-1:0], c.channel};
    endfunction

endpackage

FILE: hw/rtl/rpwu_front.sv
// word parser: padding skip, header capture and hit pair assembly
module rpwu_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic [31:0]    word,
    input  logic           last_word,
    input  logic           q_full,
    output logic           q_push,
    output rpwu_pkg::cmd_t q_data
);
    import rpwu_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [2:0]  hpos_reg, hpos_next;
    logic [7:0]  fe_reg, fe_next;
    logic [7:0]  sub_reg, sub_next;
    logic [7:0]  trig_reg, trig_next;
    logic [47:0] time_reg, time_next;
    logic [31:0] first_reg, first_next;
    logic        half_reg, half_next;
    logic [PAIR_BITS-1:0] pairs_reg, pairs_next;
    logic        accept;
    logic        emit;
    logic [PAIR_BITS-1:0] pairs_inc;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign pairs_inc = pairs_reg + PAIR_BITS'(1);

    always_comb
    begin
        phase_next = phase_reg;
        hpos_next  = hpos_reg;
        fe_next    = fe_reg;
        sub_next   = sub_reg;
        trig_next  = trig_reg;
        time_next  = time_reg;
        first_next = first_reg;
        half_next  = half_reg;
        pairs_next = pairs_reg;
        emit       = 1'b0;
        if (accept)
        begin
            unique case (phase_reg)
                PH_HEADER:
                begin
                    case (hpos_reg)
                        3'd0:
                        begin
                            fe_next   = word[31:24];
                            sub_next  = word[23:16];
                            trig_next = word[15:8];
                            hpos_next = 3'd1;
                        end
                        3'd1: hpos_next = 3'd2;
                        3'd2: hpos_next = 3'd3;
                        3'd3:
                        begin
                            time_next[47:32] = word[15:0];
                            hpos_next = 3'd4;
                        end
                        3'd4:
                        begin
                            time_next[31:0] = word;
                            hpos_next  = 3'd0;
                            phase_next = PH_HITS;
                            half_next  = 1'b0;
                            pairs_next = '0;
                        end
                        default: hpos_next = 3'd0;
                    endcase
                end
                PH_HITS:
                begin
                    if (!half_reg)
                    begin
                        first_next = word;
                        half_next  = 1'b1;
                    end
                    else
                    begin
                        half_next = 1'b0;
                        if (first_reg[31:24] == END_FIRST && word[31:24] == END_SECOND)
                        begin
                            phase_next = PH_HEADER;
                            hpos_next  = 3'd0;
                        end
                        else
                        begin
                            emit       = 1'b1;
                            pairs_next = pairs_inc;
                            if (pairs_inc >= PAIR_BITS'(MAX_PAIRS))
                            begin
                                phase_next = PH_HEADER;
                                hpos_next  = 3'd0;
                                pairs_next = '0;
                            end
                        end
                    end
                end
                default:
                begin
                    phase_next = PH_SKIP;
                    if (word[31:20] != PAD_MARK)
                    begin
                        phase_next = PH_HEADER;
                        fe_next    = word[31:24];
                        sub_next   = word[23:16];
                        trig_next  = word[15:8];
                        hpos_next  = 3'd1;
                    end
                end
            endcase
            if (last_word)
            begin
                phase_next = PH_SKIP;
                hpos_next  = 3'd0;
                half_next  = 1'b0;
                pairs_next = '0;
            end
        end
    end

    assign q_push = accept && (emit || last_word);

    always_comb
    begin
        q_data.hit            = emit;
        q_data.clr            = last_word;
        q_data.frontend_id    = fe_reg;
        q_data.sub_id         = sub_reg;
        q_data.trigger_number = trig_reg;
        q_data.trigger_time   = time_reg;
        q_data.amplitude      = first_reg[27:16];
        q_data.fine_time      = first_reg[13:0];
        q_data.channel        = word[30:24];
        q_data.coarse_epoch   = word[23:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SKIP;
            hpos_reg  <= '0;
            fe_reg    <= '0;
            sub_reg   <= '0;
            trig_reg  <= '0;
            time_reg  <= '0;
            first_reg <= '0;
            half_reg  <= 1'b0;
            pairs_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            hpos_reg  <= hpos_next;
            fe_reg    <= fe_next;
            sub_reg   <= sub_next;
            trig_reg  <= trig_next;
            time_reg  <= time_next;
            first_reg <= first_next;
            half_reg  <= half_next;
            pairs_reg <= pairs_next;
        end
    end

endmodule

FILE: hw/rtl/rpwu_queue.sv
// four entry command queue between parser and counter stage
module rpwu_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  rpwu_pkg::cmd_t push_data,
    input  logic           pop,
    output rpwu_pkg::cmd_t head,
    output logic           empty,
    output logic           full
);
    import rpwu_pkg::*;

    cmd_t       slot_reg [4];
    logic [1:0] wptr_reg;
    logic [1:0] rptr_reg;
    logic [2:0] cnt_reg;

    assign empty = (cnt_reg == 3'd0);
    assign full  = (cnt_reg == 3'd4);
    assign head  = slot_reg[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= wptr_reg + 2'd1;
            end
            if (pop)
            begin
                rptr_reg <= rptr_reg + 2'd1;
            end
            cnt_reg <= cnt_reg + 3'(push) - 3'(pop);
        end
    end

endmodule

FILE: hw/rtl/rpwu_back.sv
// per-channel counter memory, running hit total and result register
module rpwu_back (
    input  logic           clk,
    input  logic           rst_n,
    input  rpwu_pkg::cmd_t head,
    input  logic           q_empty,
    output logic           q_pop,
    output logic           out_valid,
    input  logic           out_ready,
    output rpwu_pkg::res_t res
);
    import rpwu_pkg::*;

    localparam int DEPTH = 1 << KEY_BITS;

    logic [15:0]   count_mem [DEPTH];
    logic [15:0]   rd_data_reg;
    bstate_t       state_reg, state_next;
    key_t          clr_addr_reg, clr_addr_next;
    cmd_t          hold_reg;
    logic [31:0]   total_reg;
    logic          out_valid_reg;
    res_t          res_reg;
    logic          out_free;
    logic          rd_en;
    logic          we;
    key_t          waddr;
    logic [15:0]   wdata;
    logic          load;

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        q_pop         = 1'b0;
        rd_en         = 1'b0;
        we            = 1'b0;
        waddr         = clr_addr_reg;
        wdata         = '0;
        load          = 1'b0;
        unique case (state_reg)
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop = 1'b1;
                    if (head.hit)
                    begin
                        rd_en      = 1'b1;
                        state_next = B_READ;
                    end
                    else
                    begin
                        clr_addr_next = '0;
                        state_next    = B_CLEAR;
                    end
                end
            end
            B_READ:
            begin
                if (out_free)
                begin
                    load  = 1'b1;
                    we    = 1'b1;
                    waddr = make_key(hold_reg);
                    wdata = (rd_data_reg == COUNT_MAX) ? rd_data_reg
                                                       : rd_data_reg + 16'd1;
                    if (hold_reg.clr)
                    begin
                        clr_addr_next = '0;
                        state_next    = B_CLEAR;
                    end
                    else
                    begin
                        state_next = B_IDLE;
                    end
                end
            end
            B_CLEAR:
            begin
                we            = 1'b1;
                clr_addr_next = clr_addr_reg + key_t'(1);
                if (clr_addr_reg == key_t'(DEPTH - 1))
                begin
                    state_next = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            count_mem[waddr] <= wdata;
        end
        if (rd_en)
        begin
            rd_data_reg <= count_mem[make_key(head)];
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            hold_reg <= head;
        end
        if (load)
        begin
            res_reg.frontend_id       <= hold_reg.frontend_id;
            res_reg.sub_id            <= hold_reg.sub_id;
            res_reg.trigger_number    <= hold_reg.trigger_number;
            res_reg.trigger_time      <= hold_reg.trigger_time;
            res_reg.amplitude         <= hold_reg.amplitude;
            res_reg.fine_time         <= hold_reg.fine_time;
            res_reg.channel           <= hold_reg.channel;
            res_reg.coarse_epoch      <= hold_reg.coarse_epoch;
            res_reg.channel_hit_index <= rd_data_reg;
            res_reg.hit_number        <= total_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_CLEAR;
            clr_addr_reg  <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            if (load && total_reg != TOTAL_MAX)
            begin
                total_reg <= total_reg + 32'd1;
            end
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign res       = res_reg;

    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> state_reg == B_IDLE)
        else $error("queue popped outside idle");

    a_clear_start: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != B_CLEAR && state_next == B_CLEAR) |=> clr_addr_reg == '0)
        else $error("clear sweep did not start at entry zero");

    a_total_mono: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> total_reg >= $past(total_reg))
        else $error("hit total went backwards");

    a_no_load_clear: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == B_CLEAR |-> !load)
        else $error("result loaded during clear sweep");

endmodule

FILE: hw/rtl/readout_packet_word_unpacker.sv
// top level of the readout packet word unpacker
// The unpacker takes one 32-bit readout word per cycle while the queue has
// room, on the input channel (word plus last_word) and delivers one result per
// hit word pair on the output channel. A front parser skips 0xADD padding at
// buffer start, walks the five header words and pairs up hit words, pushing
// one command per hit (and a clear request on the last word of a buffer) into
// a four-entry queue. The back stage reads the per-channel counter memory
// (2048 x 16, keyed by the low id bits and the channel), writes it back
// incremented and fills the output register; a hit passes through the idle
// and read states of the back stage, so steady input runs at one word per
// cycle while the receiver keeps out_ready high. After reset, and after every
// word flagged last_word, the back stage sweeps the counter memory to zero
// one entry per cycle; words are accepted meanwhile until the queue fills.
module readout_packet_word_unpacker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] word,
    input  logic        last_word,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  frontend_id,
    output logic [7:0]  sub_id,
    output logic [7:0]  trigger_number,
    output logic [47:0] trigger_time,
    output logic [11:0] amplitude,
    output logic [13:0] fine_time,
    output logic [6:0]  channel,
    output logic [23:0] coarse_epoch,
    output logic [15:0] channel_hit_index,
    output logic [31:0] hit_number
);
    import rpwu_pkg::*;

    // parser to queue
    logic q_push;
    cmd_t q_wdata;
    logic q_full;
    // queue to counter stage
    cmd_t q_head;
    logic q_empty;
    logic q_pop;
    res_t res;

    rpwu_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .word      (word),
        .last_word (last_word),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_data    (q_wdata)
    );

    rpwu_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_wdata),
        .pop       (q_pop),
        .head      (q_head),
        .empty     (q_empty),
        .full      (q_full)
    );

    rpwu_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (q_head),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .res       (res)
    );

    // unpack the result register onto the output ports
    assign frontend_id       = res.frontend_id;
    assign sub_id            = res.sub_id;
    assign trigger_number    = res.trigger_number;
    assign trigger_time      = res.trigger_time;
    assign amplitude         = res.amplitude;
    assign fine_time         = res.fine_time;
    assign channel           = res.channel;
    assign coarse_epoch      = res.coarse_epoch;
    assign channel_hit_index = res.channel_hit_index;
    assign hit_number        = res.hit_number;

endmodule

FILE: tb/readout_packet_word_unpacker_tb.sv
// testbench for the readout packet word unpacker: random readout buffers checked against a predictor
`timescale 1ns / 100ps

module readout_packet_word_unpacker_tb;
    import rpwu_pkg::*;

    // expected hit results in arrival order, with the unpacker state that produces them
    class hit_scoreboard;
        phase_t      ph;
        int unsigned hdr_pos;
        logic [7:0]  fe, sub, trig;
        logic [47:0] ttime;
        logic [31:0] first_word;
        bit          half;
        int unsigned pairs;
        logic [15:0] counts [0:(1<<KEY_BITS)-1];
        logic [31:0] total;
        res_t        pending[$];
        int          errors;

        function void clear_all();
            ph = PH_SKIP; hdr_pos = 0; fe = 0; sub = 0; trig = 0; ttime = 0;
            first_word = 0; half = 0; pairs = 0; total = 0; errors = 0;
            foreach (counts[i]) counts[i] = 0;
        endfunction

        function void header_word(logic [31:0] w);
            case (hdr_pos)
                0:
                begin
                    fe = w[31:24]; sub = w[23:16]; trig = w[15:8]; hdr_pos = 1;
                end
                3:
                begin
                    ttime[47:32] = w[15:0]; hdr_pos = 4;
                end
                4:
                begin
                    ttime[31:0] = w; hdr_pos = 0; ph = PH_HITS; half = 0; pairs = 0;
                end
                default: hdr_pos = hdr_pos + 1;
            endcase
        endfunction

        // called for every accepted word
        function void note_word(logic [31:0] w, logic lw);
            res_t r;
            key_t k;
            if (ph == PH_HEADER) header_word(w);
            else if (ph == PH_HITS)
            begin
                if (!half)
                begin
                    first_word = w; half = 1;
                end
                else
                begin
                    half = 0;
                    if (first_word[31:24] == END_FIRST && w[31:24] == END_SECOND)
                    begin
                        ph = PH_HEADER; hdr_pos = 0;
                    end
                    else
                    begin
                        k = {fe[FRONTEND_BITS-1:0], sub[SUB_BITS-1:0], w[30:24]};
                        r.frontend_id = fe; r.sub_id = sub; r.trigger_number = trig;
                        r.trigger_time = ttime; r.amplitude = first_word[27:16];
                        r.fine_time = first_word[13:0]; r.channel = w[30:24];
                        r.coarse_epoch = w[23:0]; r.channel_hit_index = counts[k];
                        r.hit_number = total;
                        pending.push_back(r);
                        if (counts[k] != COUNT_MAX) counts[k]++;
                        if (total != TOTAL_MAX) total++;
                        pairs++;
                        if (pairs >= MAX_PAIRS)
                        begin
                            ph = PH_HEADER; hdr_pos = 0; pairs = 0;
                        end
                    end
                end
            end
            else if (w[31:20] != PAD_MARK)
            begin
                ph = PH_HEADER; hdr_pos = 0; header_word(w);
            end
            if (lw)
            begin
                foreach (counts[i]) counts[i] = 0;
                ph = PH_SKIP; hdr_pos = 0; half = 0; pairs = 0;
            end
        endfunction

        function void check_hit(res_t got);
            res_t e;
            if (pending.size() == 0)
            begin
                $error("unexpected result");
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.frontend_id != e.frontend_id)
            begin $error("frontend_id exp %0h got %0h", e.frontend_id, got.frontend_id); errors++; end
            if (got.sub_id != e.sub_id)
            begin $error("sub_id exp %0h got %0h", e.sub_id, got.sub_id); errors++; end
            if (got.trigger_number != e.trigger_number)
            begin
                $error("trigger_number exp %0h got %0h", e.trigger_number, got.trigger_number);
                errors++;
            end
            if (got.trigger_time != e.trigger_time)
            begin
                $error("trigger_time exp %0h got %0h", e.trigger_time, got.trigger_time);
                errors++;
            end
            if (got.amplitude != e.amplitude)
            begin $error("amplitude exp %0h got %0h", e.amplitude, got.amplitude); errors++; end
            if (got.fine_time != e.fine_time)
            begin $error("fine_time exp %0h got %0h", e.fine_time, got.fine_time); errors++; end
            if (got.channel != e.channel)
            begin $error("channel exp %0h got %0h", e.channel, got.channel); errors++; end
            if (got.coarse_epoch != e.coarse_epoch)
            begin
                $error("coarse_epoch exp %0h got %0h", e.coarse_epoch, got.coarse_epoch);
                errors++;
            end
            if (got.channel_hit_index != e.channel_hit_index)
            begin
                $error("channel_hit_index exp %0d got %0d", e.channel_hit_index,
                       got.channel_hit_index);
                errors++;
            end
            if (got.hit_number != e.hit_number)
            begin $error("hit_number exp %0d got %0d", e.hit_number, got.hit_number); errors++; end
        endfunction
    endclass

    logic        clk = 0;
    logic        rst_n = 0;
    logic        in_valid = 0;
    logic        in_ready;
    logic [31:0] word = 0;
    logic        last_word = 0;
    logic        out_valid;
    logic        out_ready = 0;
    res_t        result;

    hit_scoreboard sb;
    int  burst_left = 0;
    bit  stim_done = 0;

    readout_packet_word_unpacker u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .word(word), .last_word(last_word),
        .out_valid(out_valid), .out_ready(out_ready),
        .frontend_id(result.frontend_id), .sub_id(result.sub_id),
        .trigger_number(result.trigger_number), .trigger_time(result.trigger_time),
        .amplitude(result.amplitude), .fine_time(result.fine_time),
        .channel(result.channel), .coarse_epoch(result.coarse_epoch),
        .channel_hit_index(result.channel_hit_index), .hit_number(result.hit_number)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // send one word: random gaps between bursts, valid held until accepted
    task automatic send_word(input logic [31:0] w, input logic lw);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 6);
            if (gap > 0)
            begin
                in_valid <= 0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 30);
        end
        burst_left--;
        in_valid <= 1; word <= w; last_word <= lw;
        do @(posedge clk); while (!in_ready);
        sb.note_word(w, lw);
        @(negedge clk);
    endtask

    // one packet: header, n hit pairs (some ending in a channel-dense pattern), optional end marker
    task automatic send_packet(input int n_hits, input bit with_end, input bit last_after);
        logic [31:0] hw0;
        hw0 = $urandom;
        if (hw0[31:20] == PAD_MARK) hw0[31] = 0;
        send_word(hw0, 0);
        send_word($urandom, 0);
        send_word($urandom, 0);
        send_word($urandom, 0);
        send_word($urandom, !with_end && n_hits == 0 && last_after);
        for (int i = 0; i < n_hits; i++)
        begin
            logic [31:0] a, b;
            a = $urandom; b = $urandom;
            if ($urandom_range(0, 2) == 0) b[30:24] = 7'($urandom_range(0, 3));
            if (a[31:24] == END_FIRST && b[31:24] == END_SECOND) b[24] = ~b[24];
            send_word(a, 0);
            send_word(b, !with_end && i == n_hits - 1 && last_after);
        end
        if (with_end)
        begin
            send_word({END_FIRST, 24'($urandom)}, 0);
            send_word({END_SECOND, 24'($urandom)}, last_after);
        end
    endtask

    // receiver stalls on a random pattern, and is always ready once stimulus is done
    always @(negedge clk)
    begin
        if (($urandom_range(0, 99) < 3) || stim_done)
            out_ready <= stim_done ? 1'b1 : 1'b1;
        else if ($urandom_range(0, 3) == 0)
            out_ready <= 0;
        else
            out_ready <= 1;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready) sb.check_hit(result);
    end

    initial
    begin
        int sent_pkts;
        sb = new();
        sb.clear_all();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1;

        // directed: padding, extremes, padding-looking data, end marker, cut-off packet
        send_word({PAD_MARK, 20'h00000}, 0);
        send_word({PAD_MARK, 20'hFFFFF}, 0);
        send_word(32'hFFFF_FFFF, 0);
        send_word(32'h0, 0);
        send_word(32'h0, 0);
        send_word(32'h0000_FFFF, 0);
        send_word(32'hFFFF_FFFF, 0);
        send_word(32'hFFFF_FFFF, 0);
        send_word(32'h7FFF_FFFF, 0);
        send_word({PAD_MARK, 20'h12345}, 0);
        send_word(32'h0000_0000, 0);
        send_word({END_FIRST, 24'h0}, 0);
        send_word({END_SECOND, 24'h0}, 0);
        send_packet(2, 0, 0);
        send_word(32'h1234_5678, 1);
        send_packet(3, 0, 1);

        // random buffers of short packets
        sent_pkts = 0;
        while (sent_pkts < 37)
        begin
            int np;
            repeat ($urandom_range(0, 2)) send_word({PAD_MARK, 20'($urandom)}, 0);
            np = $urandom_range(1, 3);
            for (int p = 0; p < np; p++)
            begin
                bit lastp;
                lastp = (p == np - 1);
                if ($urandom_range(0, 9) == 0)
                begin
                    send_word($urandom, 0);
                    send_word($urandom, lastp);
                end
                else
                    send_packet($urandom_range(0, 5), $urandom_range(0, 3) != 0, lastp);
                sent_pkts++;
            end
        end
        send_packet(2, 1, 1);
        in_valid <= 0;

        stim_done = 1;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (50) @(posedge clk);
        if (sb.errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("end of test: mismatches");
        $finish;
    end
endmodule
